### hdl/ibt_pkg.sv
// ----------------------------------------------------------------------------
// ibt_pkg: shared types and constants of the in-place butterfly transform
// Store geometry, field widths, action and mode codes, and the transaction
// and internal control structs used by more than one file.
// ----------------------------------------------------------------------------
package ibt_pkg;

  // Store geometry
  localparam int LOG2_DEPTH = 10;
  localparam int DEPTH      = 1 << LOG2_DEPTH;
  localparam int ADDR_W     = LOG2_DEPTH;
  localparam int PAIR_W     = (LOG2_DEPTH > 1) ? LOG2_DEPTH - 1 : 1;
  localparam int STAGE_W    = $clog2(LOG2_DEPTH + 1);

  // Field widths
  localparam int WORD_W      = 32;
  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 10;
  localparam int MODE_W      = 2;
  localparam int LOG2_SIZE_W = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_WRITE     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TRANSFORM = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ      = 2'd2;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_WHT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ZETA   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOBIUS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XOR    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOG2_SIZE = 1'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  index;
    logic [WORD_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic              finished;
  } out_item_t;

  // Butterfly operand addresses from the address generator
  typedef struct packed {
    logic [ADDR_W-1:0] top;
    logic [ADDR_W-1:0] bot;
    logic              last;
  } addr_pair_t;

  // Butterfly results
  typedef struct packed {
    logic [WORD_W-1:0] top;
    logic [WORD_W-1:0] bot;
  } bf_res_t;

endpackage

### hdl/ibt_ram.sv
// ----------------------------------------------------------------------------
// ibt_ram: generic RAM, one write port and two registered read ports
// Write data lands at the clock edge; read data appears in the cycle after the
// address.
// ----------------------------------------------------------------------------
module ibt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/ibt_bfly.sv
// ----------------------------------------------------------------------------
// ibt_bfly: shared radix-2 butterfly unit
// Combines one operand pair according to the transform mode; all arithmetic
// wraps modulo 2^32.
// ----------------------------------------------------------------------------
module ibt_bfly (
  input  logic [ibt_pkg::MODE_W-1:0] mode,
  input  logic [ibt_pkg::WORD_W-1:0] a,
  input  logic [ibt_pkg::WORD_W-1:0] b,
  output ibt_pkg::bf_res_t           res
);
  import ibt_pkg::*;

  always_comb begin
    res.top = a;
    case (mode)
      MODE_WHT: begin
        res.top = a + b;
        res.bot = a - b;
      end
      MODE_ZETA: begin
        res.bot = a + b;
      end
      MODE_MOBIUS: begin
        res.bot = b - a;
      end
      default: begin
        res.bot = a ^ b;
      end
    endcase
  end

endmodule

### hdl/ibt_agu.sv
// ----------------------------------------------------------------------------
// ibt_agu: butterfly address generator
// Walks stage by stage and pair by pair; the top address is the pair count
// with a zero inserted at the stage bit, the bottom address sets that bit.
// ----------------------------------------------------------------------------
module ibt_agu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        step,
  input  logic [ibt_pkg::STAGE_W-1:0] stages,
  output ibt_pkg::addr_pair_t         pair
);
  import ibt_pkg::*;

  logic [STAGE_W-1:0] stage;
  logic [PAIR_W-1:0]  pair_idx;
  logic [ADDR_W-1:0]  idx_ext;
  logic [ADDR_W-1:0]  low_mask;
  logic [ADDR_W-1:0]  last_idx;
  logic               last_pair;
  logic               last_stage;

  always_comb begin
    idx_ext    = ADDR_W'(pair_idx);
    low_mask   = (ADDR_W'(1) << stage) - ADDR_W'(1);
    last_idx   = (ADDR_W'(1) << (stages - STAGE_W'(1))) - ADDR_W'(1);
    last_pair  = (idx_ext == last_idx);
    last_stage = (stage == stages - STAGE_W'(1));
    pair.top   = ((idx_ext & ~low_mask) << 1) | (idx_ext & low_mask);
    pair.bot   = pair.top | (ADDR_W'(1) << stage);
    pair.last  = last_pair && last_stage;
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      stage    <= '0;
      pair_idx <= '0;
    end else if (step) begin
      if (last_pair) begin
        pair_idx <= '0;
        stage    <= stage + STAGE_W'(1);
      end else begin
        pair_idx <= pair_idx + PAIR_W'(1);
      end
    end
  end

  // Top and bottom of a butterfly in progress differ in exactly the stage bit
  a_pair_split: assert property (@(posedge clk) disable iff (rst)
    step |-> $onehot(pair.top ^ pair.bot))
    else $error("butterfly addresses do not differ in one bit");

  // Top always has the stage bit clear
  a_top_clear: assert property (@(posedge clk) disable iff (rst)
    ((pair.top & pair.bot) == pair.top))
    else $error("top address carries bits the bottom lacks");

  // A restart always begins at the first pair of the first stage
  a_restart: assert property (@(posedge clk) disable iff (rst)
    start |=> (pair.top == '0))
    else $error("address generator did not restart at zero");

endmodule

### hdl/inplace_butterfly_transform.sv
// ----------------------------------------------------------------------------
// inplace_butterfly_transform: in-place Walsh-Hadamard family transform engine
// A 1024-word store takes write and read transactions; a transform
// transaction runs log2_size radix-2 butterfly stages (capped at 10) in
// place over the first 2^stages words; the mode register picks the butterfly.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake          | Payload
//   ---------+-----------+--------------------+---------------------------------
//   in       | input     | in_valid/in_stall   | in_item: action, index, value
//   out      | output    | out_valid/out_stall | out_item: read_value, finished
//   cfg      | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
// Transactions: a read goes through the registered RAM read. A transform runs
// B = (2^stages/2)*stages butterflies; in Walsh-Hadamard mode each reads the
// pair, writes the bottom, then writes the top through the single RAM write
// port; in the other modes each reads the pair and writes the bottom only.
// Reset: rst is synchronous, active high; it clears the sequencer, the output
// valid and the registers (mode 0, log2_size 10). Store contents are not
// cleared and are undefined until written.
// Stalls: the next transaction is taken while a result sits in the output
// register as long as out_stall is low; a held result blocks new input.
// ----------------------------------------------------------------------------
module inplace_butterfly_transform (
  input  logic                            clk,
  input  logic                            rst,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ibt_pkg::in_item_t               in_item,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output ibt_pkg::out_item_t              out_item,
  // configuration port
  input  logic                            cfg_we,
  input  logic [ibt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ibt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ibt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_BF_RD,
    S_BF_WB,
    S_BF_WT
  } state_t;

  state_t                 state;
  logic [MODE_W-1:0]      mode;
  logic [LOG2_SIZE_W-1:0] log2_size;
  logic [STAGE_W-1:0]     stages;
  logic [WORD_W-1:0]      top_hold;

  logic                   in_accept;
  logic [ADDR_W-1:0]      in_addr;
  logic                   agu_start;
  logic                   agu_step;
  addr_pair_t             pair;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr_a;
  logic [WORD_W-1:0]      ram_rdata_a;
  logic [WORD_W-1:0]      ram_rdata_b;
  bf_res_t                bf_res;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_WHT;
      log2_size <= LOG2_SIZE_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:      mode      <= cfg_data[MODE_W-1:0];
        CFG_LOG2_SIZE: log2_size <= cfg_data[LOG2_SIZE_W-1:0];
        default:       ;
      endcase
    end
  end

  // Saturate the transform size at the store depth
  assign stages = (int'(log2_size) > LOG2_DEPTH) ? STAGE_W'(LOG2_DEPTH)
                                                 : STAGE_W'(log2_size);

  // --------------------------------------------------------------------------
  // Handshake: take input only when idle and the output register frees up
  // --------------------------------------------------------------------------
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign in_addr   = in_item.index[ADDR_W-1:0];   // wrap to the store depth

  // --------------------------------------------------------------------------
  // Address generator and butterfly unit
  // --------------------------------------------------------------------------
  assign agu_start = in_accept;
  // Advance after the last write of each butterfly
  assign agu_step  = ((state == S_BF_WB) && (mode != MODE_WHT)) || (state == S_BF_WT);

  ibt_agu u_agu (
    .clk    (clk),
    .rst    (rst),
    .start  (agu_start),
    .step   (agu_step),
    .stages (stages),
    .pair   (pair)
  );

  ibt_bfly u_bfly (
    .mode (mode),
    .a    (ram_rdata_a),
    .b    (ram_rdata_b),
    .res  (bf_res)
  );

  // --------------------------------------------------------------------------
  // Store: port A serves host reads and butterfly tops, port B the bottoms
  // --------------------------------------------------------------------------
  always_comb begin
    ram_raddr_a = (state == S_IDLE) ? in_addr : pair.top;
    ram_we      = 1'b0;
    ram_waddr   = in_addr;
    ram_wdata   = in_item.value;
    case (state)
      S_IDLE: begin
        ram_we = in_accept && (in_item.action == ACT_WRITE);
      end
      S_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = pair.bot;
        ram_wdata = bf_res.bot;
      end
      S_BF_WT: begin
        ram_we    = 1'b1;
        ram_waddr = pair.top;
        ram_wdata = top_hold;
      end
      default: ;
    endcase
  end

  ibt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (pair.bot),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken; a new one below overrides this
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (in_item.action)
              ACT_WRITE: begin
                out_valid <= 1'b1;
                out_item  <= '{read_value: '0, finished: 1'b0};
              end
              ACT_TRANSFORM: begin
                if (stages == '0) begin
                  out_valid <= 1'b1;
                  out_item  <= '{read_value: '0, finished: 1'b1};
                end else begin
                  state <= S_BF_RD;
                end
              end
              ACT_READ: begin
                state <= S_READ;
              end
              default: begin
                // unused action: no state change, empty result
                out_valid <= 1'b1;
                out_item  <= '{read_value: '0, finished: 1'b0};
              end
            endcase
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          out_item  <= '{read_value: ram_rdata_a, finished: 1'b0};
          state     <= S_IDLE;
        end
        S_BF_RD: begin
          // operand pair is in flight through the RAM read register
          state <= S_BF_WB;
        end
        S_BF_WB: begin
          top_hold <= bf_res.top;
          if (mode == MODE_WHT) begin
            state <= S_BF_WT;
          end else if (pair.last) begin
            out_valid <= 1'b1;
            out_item  <= '{read_value: '0, finished: 1'b1};
            state     <= S_IDLE;
          end else begin
            state <= S_BF_RD;
          end
        end
        S_BF_WT: begin
          if (pair.last) begin
            out_valid <= 1'b1;
            out_item  <= '{read_value: '0, finished: 1'b1};
            state     <= S_IDLE;
          end else begin
            state <= S_BF_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A held result must block new transactions
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !in_accept)
    else $error("transaction accepted while a result was held");

  // No result is pending while butterflies run
  a_quiet_transform: assert property (@(posedge clk) disable iff (rst)
    (state == S_BF_RD || state == S_BF_WB || state == S_BF_WT) |-> !out_valid)
    else $error("result pending during a transform");

  // Store writes come only from a write transaction or a butterfly
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((in_accept && in_item.action == ACT_WRITE) ||
                state == S_BF_WB || state == S_BF_WT))
    else $error("unexpected store write");

  // The top write always follows the bottom write of the same butterfly
  a_top_after_bot: assert property (@(posedge clk) disable iff (rst)
    (state == S_BF_WT) |-> ($past(state) == S_BF_WB && mode == MODE_WHT))
    else $error("top write out of sequence");

endmodule
